// ===== sv/rpn_pkg.sv =====
// Shared constants, command codes and controller/datapath structs for the RPN evaluator.
package rpn_pkg;

  localparam int DATA_W          = 64;
  localparam int CMD_W           = 3;
  localparam int STACK_DEPTH_DEF = 64;

  localparam logic [CMD_W-1:0] CMD_PUSH = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SUB  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_MUL  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DIV  = 3'd4;

  localparam logic [1:0] MUL_PH_LO = 2'd0;
  localparam logic [1:0] MUL_PH_X1 = 2'd1;
  localparam logic [1:0] MUL_PH_X2 = 2'd2;

  typedef struct packed {
    logic             push;
    logic             set_inv;
    logic             mul_en;
    logic [1:0]       mul_phase;
    logic             div_start;
    logic             wb;
    logic             emit;
    logic [CMD_W-1:0] op;
  } ctrl_t;

  typedef struct packed {
    logic inv;
    logic full;
    logic lt2;
    logic b_zero;
    logic div_done;
    logic out_free;
  } stat_t;

endpackage

// ===== sv/rpn_if.sv =====
// Token request and result request channel interfaces.
interface rpn_in_if import rpn_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         cmd;
  logic signed [DATA_W-1:0] number;
  logic                     last_token;

  modport source (output valid, output cmd, output number, output last_token, input ready);
  modport sink   (input valid, input cmd, input number, input last_token, output ready);
endinterface

interface rpn_out_if import rpn_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] answer;
  logic                     failed;

  modport source (output valid, output answer, output failed, input ready);
  modport sink   (input valid, input answer, input failed, output ready);
endinterface

// ===== sv/rpn_div.sv =====
// Iterative restoring divider, one quotient bit per cycle, truncating signed result.
module rpn_div import rpn_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DATA_W-1:0] dividend,
  input  logic [DATA_W-1:0] divisor,
  output logic              done,
  output logic [DATA_W-1:0] quotient
);

  localparam int CW = $clog2(DATA_W + 1);
  localparam logic [CW-1:0] STEPS    = CW'(DATA_W);
  localparam logic [CW-1:0] CNT_ONE  = CW'(1);
  localparam logic [CW-1:0] CNT_ZERO = '0;

  logic [CW-1:0]     cnt_r;
  logic              done_r;
  logic [DATA_W-1:0] num_r;
  logic [DATA_W-1:0] den_r;
  logic [DATA_W-1:0] rem_r;
  logic              neg_r;

  logic              a_neg;
  logic              b_neg;
  logic [DATA_W-1:0] a_mag;
  logic [DATA_W-1:0] b_mag;
  logic [DATA_W-1:0] rem_sh;
  logic              ge;

  assign a_neg  = dividend[DATA_W-1];
  assign b_neg  = divisor[DATA_W-1];
  assign a_mag  = a_neg ? ('0 - dividend) : dividend;
  assign b_mag  = b_neg ? ('0 - divisor) : divisor;
  assign rem_sh = {rem_r[DATA_W-2:0], num_r[DATA_W-1]};
  assign ge     = (rem_sh >= den_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= CNT_ZERO;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= STEPS;
      end else if (cnt_r != CNT_ZERO) begin
        cnt_r <= cnt_r - CNT_ONE;
        if (cnt_r == CNT_ONE) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= a_mag;
      den_r <= b_mag;
      rem_r <= '0;
      neg_r <= a_neg ^ b_neg;
    end else if (cnt_r != CNT_ZERO) begin
      rem_r <= ge ? (rem_sh - den_r) : rem_sh;
      num_r <= {num_r[DATA_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? ('0 - num_r) : num_r;

  a_done_after_last_step: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (cnt_r == CNT_ZERO) && ($past(cnt_r) == CNT_ONE))
    else $error("divider done without finishing its steps");

  a_no_restart_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> (cnt_r == CNT_ZERO))
    else $error("divider restarted while busy");

endmodule

// ===== sv/rpn_dpath.sv =====
// Operand stack, top-of-stack register, ALU, multiplier, divider and result register.
module rpn_dpath import rpn_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ctrl_t                    ctl,
  output stat_t                    st,
  input  logic signed [DATA_W-1:0] in_number,
  output logic signed [DATA_W-1:0] out_answer,
  output logic                     out_failed,
  output logic                     out_valid,
  input  logic                     out_ready
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int HW = DATA_W / 2;
  localparam logic [DW-1:0] DEPTH_MAX  = DW'(STACK_DEPTH);
  localparam logic [DW-1:0] DEPTH_ONE  = DW'(1);
  localparam logic [DW-1:0] DEPTH_TWO  = DW'(2);
  localparam logic [DW-1:0] DEPTH_ZERO = '0;

  logic [DATA_W-1:0] mem [STACK_DEPTH];

  logic [DW-1:0]     depth_r;
  logic              inv_r;
  logic [DATA_W-1:0] tos_r;
  logic [DATA_W-1:0] rdata_r;
  logic [DATA_W-1:0] acc_r;
  logic              out_valid_r;
  logic [DATA_W-1:0] answer_r;
  logic              failed_r;

  logic [DW-1:0]     wr_diff;
  logic [DW-1:0]     rd_diff;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     rd_addr;
  logic [HW-1:0]     mul_x;
  logic [HW-1:0]     mul_y;
  logic [DATA_W-1:0] mul_p;
  logic [DATA_W-1:0] res;
  logic [DATA_W-1:0] quotient;
  logic              div_done;
  logic              line_fail;

  assign wr_diff = depth_r - DEPTH_ONE;
  assign rd_diff = depth_r - DEPTH_TWO;
  assign wr_addr = wr_diff[AW-1:0];
  assign rd_addr = rd_diff[AW-1:0];

  always_ff @(posedge clk) begin
    if (ctl.push && (depth_r != DEPTH_ZERO)) begin
      mem[wr_addr] <= tos_r;
    end
    rdata_r <= mem[rd_addr];
  end

  rpn_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctl.div_start),
    .dividend (rdata_r),
    .divisor  (tos_r),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    case (ctl.mul_phase)
      MUL_PH_X1: begin
        mul_x = rdata_r[HW-1:0];
        mul_y = tos_r[DATA_W-1:HW];
      end
      MUL_PH_X2: begin
        mul_x = rdata_r[DATA_W-1:HW];
        mul_y = tos_r[HW-1:0];
      end
      default: begin
        mul_x = rdata_r[HW-1:0];
        mul_y = tos_r[HW-1:0];
      end
    endcase
  end

  assign mul_p = DATA_W'(mul_x) * DATA_W'(mul_y);

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      if (ctl.mul_phase == MUL_PH_LO) begin
        acc_r <= mul_p;
      end else begin
        acc_r[DATA_W-1:HW] <= acc_r[DATA_W-1:HW] + mul_p[HW-1:0];
      end
    end
  end

  always_comb begin
    case (ctl.op)
      CMD_ADD: res = rdata_r + tos_r;
      CMD_SUB: res = rdata_r - tos_r;
      CMD_MUL: res = acc_r;
      CMD_DIV: res = quotient;
      default: res = tos_r;
    endcase
  end

  assign line_fail = inv_r || (depth_r != DEPTH_ONE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r     <= DEPTH_ZERO;
      inv_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.emit) begin
        depth_r <= DEPTH_ZERO;
        inv_r   <= 1'b0;
      end else begin
        if (ctl.push) begin
          depth_r <= depth_r + DEPTH_ONE;
        end else if (ctl.wb) begin
          depth_r <= depth_r - DEPTH_ONE;
        end
        if (ctl.set_inv) begin
          inv_r <= 1'b1;
        end
      end
      if (ctl.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      tos_r <= in_number;
    end else if (ctl.wb) begin
      tos_r <= res;
    end
    if (ctl.emit) begin
      answer_r <= line_fail ? '0 : tos_r;
      failed_r <= line_fail;
    end
  end

  assign st.inv      = inv_r;
  assign st.full     = (depth_r == DEPTH_MAX);
  assign st.lt2      = (depth_r < DEPTH_TWO);
  assign st.b_zero   = (tos_r == '0);
  assign st.div_done = div_done;
  assign st.out_free = !out_valid_r || out_ready;

  assign out_valid  = out_valid_r;
  assign out_answer = $signed(answer_r);
  assign out_failed = failed_r;

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DEPTH_MAX)
    else $error("stack depth beyond capacity");

  a_wb_has_operands: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.wb |-> (depth_r >= DEPTH_TWO) && !inv_r)
    else $error("operator write-back without two operands");

  a_emit_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit |-> (!out_valid_r || out_ready))
    else $error("result overwritten before it was taken");

endmodule

// ===== sv/rpn_ctrl.sv =====
// Token sequencer: decodes each request and steps the datapath through its operation.
module rpn_ctrl import rpn_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [CMD_W-1:0] in_cmd,
  input  logic             in_last,
  input  stat_t            st,
  output ctrl_t            ctl
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_OPR  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_WB   = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]       state_r;
  logic [2:0]       state_nxt;
  logic [CMD_W-1:0] op_r;
  logic [CMD_W-1:0] op_nxt;
  logic             last_r;
  logic             last_nxt;
  logic [1:0]       cnt_r;
  logic [1:0]       cnt_nxt;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    last_nxt      = last_r;
    cnt_nxt       = cnt_r;
    in_ready      = 1'b0;
    ctl           = '0;
    ctl.op        = op_r;
    ctl.mul_phase = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt    = in_cmd;
          last_nxt  = in_last;
          state_nxt = S_FIN;
          if (st.inv) begin
            state_nxt = S_FIN;
          end else if (in_cmd == CMD_PUSH) begin
            if (st.full) begin
              ctl.set_inv = 1'b1;
            end else begin
              ctl.push = 1'b1;
            end
          end else if (in_cmd > CMD_DIV) begin
            ctl.set_inv = 1'b1;
          end else if (st.lt2) begin
            ctl.set_inv = 1'b1;
          end else begin
            state_nxt = S_OPR;
          end
        end
      end
      S_OPR: begin
        unique case (op_r) inside
          CMD_ADD, CMD_SUB: state_nxt = S_WB;
          CMD_MUL: begin
            ctl.mul_en    = 1'b1;
            ctl.mul_phase = MUL_PH_LO;
            cnt_nxt       = MUL_PH_X1;
            state_nxt     = S_MUL;
          end
          CMD_DIV: begin
            if (st.b_zero) begin
              ctl.set_inv = 1'b1;
              state_nxt   = S_FIN;
            end else begin
              ctl.div_start = 1'b1;
              state_nxt     = S_DIV;
            end
          end
          default: state_nxt = S_FIN;
        endcase
      end
      S_MUL: begin
        ctl.mul_en = 1'b1;
        if (cnt_r == MUL_PH_X2) begin
          state_nxt = S_WB;
        end else begin
          cnt_nxt = cnt_r + 2'd1;
        end
      end
      S_DIV: begin
        if (st.div_done) begin
          state_nxt = S_WB;
        end
      end
      S_WB: begin
        ctl.wb    = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!last_r) begin
          state_nxt = S_IDLE;
        end else if (st.out_free) begin
          ctl.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= MUL_PH_LO;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    last_r <= last_nxt;
  end

endmodule

// ===== sv/rpn_stack_evaluator_top.sv =====
// Top level of the reverse Polish expression evaluator.
//
// in_ch carries one pre-parsed token per request: cmd (push, add, subtract,
// multiply, divide, or a bad token), the 64-bit signed number for a push,
// and last_token on the final token of a line. out_ch carries one result per
// line: answer and failed (answer is zero when failed is set).
// Multiply forms three 32x32 partial products through one shared
// multiplier, and divide produces one quotient bit per cycle in the
// restoring divider. Tokens after a fault, bad tokens and short-stack
// operators do no stack work. The result is registered into the output
// register at line end once the previous result has been taken.
// The operand stack lives in a single-port-write, registered-read memory;
// the top entry is held in a register.
// Reset clears the depth, the fault flag, the controller state and the output
// valid; no clearing pass is run. While a result waits on a stalled
// receiver the block keeps taking tokens; it holds only at the next line
// end until the waiting result is taken.
module rpn_stack_evaluator_top import rpn_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input logic clk,
  input logic rst_n,
  rpn_in_if.sink    in_ch,
  rpn_out_if.source out_ch
);

  ctrl_t ctl;
  stat_t st;

  rpn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_cmd   (in_ch.cmd),
    .in_last  (in_ch.last_token),
    .st       (st),
    .ctl      (ctl)
  );

  rpn_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .st         (st),
    .in_number  (in_ch.number),
    .out_answer (out_ch.answer),
    .out_failed (out_ch.failed),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready)
  );

endmodule
